// ===== design/contiguous_fit_allocator_defines.svh =====
// Assertion macros shared by the allocator modules.
`ifndef CONTIGUOUS_FIT_ALLOCATOR_DEFINES_SVH
`define CONTIGUOUS_FIT_ALLOCATOR_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define CFA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define CFA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define CFA_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define CFA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== design/cfa_pkg.sv =====
`timescale 1ns / 1ps
package cfa_pkg;
  localparam int MaxSegments = 32;
  localparam int AddrBits    = 20;
  localparam int IdBits      = 16;
  localparam int SizeBits    = AddrBits + 1;
  localparam int IdxBits     = $clog2(MaxSegments);
  localparam int CntBits     = $clog2(MaxSegments + 1);
  localparam logic [SizeBits-1:0] SpaceCap = SizeBits'(1) << AddrBits;

  localparam logic OP_REQUEST = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_BEST  = 2'd1;
  localparam logic [1:0] FIT_WORST = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NO_FIT    = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_ZERO      = 3'd4;

  typedef struct packed {
    logic                op;
    logic [IdBits-1:0]   owner_id;
    logic [SizeBits-1:0] request_size;
    logic [1:0]          fit_mode;
  } in_item_t;

  typedef struct packed {
    logic [2:0]          status;
    logic [AddrBits-1:0] start_address;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_DECIDE, S_SHIFT, S_SPLIT, S_FREE, S_MERGE, S_CLEAR, S_DONE, S_INIT
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;
    logic init;
    logic scan_step;
    logic shift_step;
    logic split;
    logic exact;
    logic free_step;
    logic merge_step;
    logic clear_step;
    logic idx_reset;
    logic idx_to_count;
    logic set_status;
    logic [2:0] status;
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic op;
    logic zero_size;
    logic bad_mode;
    logic idx_end;
    logic first_hit;
    logic picked;
    logic pick_exact;
    logic full;
    logic shift_end;
    logic found;
    logic clear_end;
  } dp_stat_t;
endpackage

// ===== design/cfa_ctrl.sv =====
`timescale 1ns / 1ps
`include "contiguous_fit_allocator_defines.svh"
module cfa_ctrl import cfa_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_go,
  input  logic     cfg_go,
  input  logic     out_free,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd,
  output logic     busy,
  output logic     out_load
);
  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (cfg_go) state_nxt = S_INIT;
        else if (in_go) state_nxt = S_SCAN;
      end
      S_INIT: state_nxt = S_IDLE;
      S_SCAN: begin
        if (stat.op == OP_RELEASE) state_nxt = S_FREE;
        else if (stat.zero_size || stat.bad_mode) state_nxt = S_DONE;
        else if (stat.idx_end || stat.first_hit) state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        if (!stat.picked || stat.pick_exact || stat.full) state_nxt = S_DONE;
        else state_nxt = S_SHIFT;
      end
      S_SHIFT: if (stat.shift_end) state_nxt = S_SPLIT;
      S_SPLIT: state_nxt = S_DONE;
      S_FREE: begin
        if (stat.idx_end) state_nxt = stat.found ? S_MERGE : S_DONE;
      end
      S_MERGE: if (stat.idx_end) state_nxt = S_CLEAR;
      S_CLEAR: if (stat.clear_end) state_nxt = S_DONE;
      S_DONE: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    out_load = 1'b0;
    busy = (state_r != S_IDLE);
    case (state_r)
      S_IDLE: begin
        cmd.load = in_go && !cfg_go;
        cmd.idx_reset = 1'b1;
      end
      S_INIT: cmd.init = 1'b1;
      S_SCAN: begin
        if (stat.op == OP_RELEASE) begin
          cmd.free_step = 1'b1;
        end else if (stat.zero_size) begin
          cmd.set_status = 1'b1;
          cmd.status = ST_ZERO;
        end else if (stat.bad_mode) begin
          cmd.set_status = 1'b1;
          cmd.status = ST_NO_FIT;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_DECIDE: begin
        cmd.set_status = 1'b1;
        if (!stat.picked) cmd.status = ST_NO_FIT;
        else if (stat.pick_exact) begin
          cmd.status = ST_OK;
          cmd.exact = 1'b1;
        end else if (stat.full) cmd.status = ST_FULL;
        else begin
          cmd.status = ST_OK;
          cmd.idx_to_count = 1'b1;
        end
      end
      S_SHIFT: cmd.shift_step = 1'b1;
      S_SPLIT: cmd.split = 1'b1;
      S_FREE: begin
        if (stat.idx_end) begin
          cmd.idx_reset = 1'b1;
          cmd.set_status = 1'b1;
          cmd.status = stat.found ? ST_OK : ST_NOT_FOUND;
        end else begin
          cmd.free_step = 1'b1;
        end
      end
      S_MERGE: cmd.merge_step = 1'b1;
      S_CLEAR: cmd.clear_step = 1'b1;
      S_DONE: out_load = out_free;
      default: ;
    endcase
  end

  `CFA_ASSERT_NEXT(a_init_returns, clk, rst_n, state_r == S_INIT, state_r == S_IDLE)
  `CFA_ASSERT_IMPL(a_one_mut, clk, rst_n, 1'b1,
    $countones({cmd.shift_step, cmd.split, cmd.merge_step, cmd.init}) <= 1)
  `CFA_ASSERT_NEXT(a_split_done, clk, rst_n, state_r == S_SPLIT, state_r == S_DONE)
endmodule

// ===== design/cfa_dp.sv =====
`timescale 1ns / 1ps
`include "contiguous_fit_allocator_defines.svh"
module cfa_dp import cfa_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  in_item_t            in_item,
  input  logic [SizeBits-1:0] cfg_space,
  input  dp_cmd_t             cmd,
  output dp_stat_t            stat,
  output out_item_t           result
);
  // Segment table in flops: entries are shifted and compacted one per cycle.
  logic [AddrBits-1:0] start_r [MaxSegments];
  logic [SizeBits-1:0] size_r  [MaxSegments];
  logic [IdBits-1:0]   owner_r [MaxSegments];
  logic [MaxSegments-1:0] used_r;
  logic [CntBits-1:0]  count_r;
  logic [SizeBits-1:0] space_r;

  in_item_t            item_r;
  logic [CntBits-1:0]  idx_r;   // read pointer for scans, also shift pointer
  logic [IdxBits-1:0]  wr_r;    // merge write pointer
  logic [IdxBits-1:0]  pick_r;
  logic                picked_r;
  logic                found_r;
  out_item_t           result_r;

  logic [IdxBits-1:0]  ix;
  logic                fits;
  logic                better;

  assign ix = idx_r[IdxBits-1:0];
  assign fits = (idx_r < count_r) && !used_r[ix] && (size_r[ix] >= item_r.request_size);
  always_comb begin
    better = 1'b0;
    if (!picked_r) better = 1'b1;
    else if (item_r.fit_mode == FIT_BEST) better = size_r[ix] < size_r[pick_r];
    else if (item_r.fit_mode == FIT_WORST) better = size_r[ix] > size_r[pick_r];
  end

  always_comb begin
    stat.op = item_r.op;
    stat.zero_size = (item_r.request_size == '0);
    stat.bad_mode = (item_r.fit_mode != FIT_FIRST) && (item_r.fit_mode != FIT_BEST)
                    && (item_r.fit_mode != FIT_WORST);
    stat.idx_end = (idx_r >= count_r);
    stat.first_hit = fits && (item_r.fit_mode == FIT_FIRST);
    stat.picked = picked_r;
    stat.pick_exact = (size_r[pick_r] == item_r.request_size);
    stat.full = (count_r >= CntBits'(MaxSegments));
    stat.shift_end = (idx_r <= CntBits'(pick_r) + CntBits'(1));
    stat.found = found_r;
    stat.clear_end = 1'b1;
  end

  assign result = result_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      space_r  <= SpaceCap;
      count_r  <= CntBits'(1);
      used_r   <= '0;
      start_r[0] <= '0;
      size_r[0]  <= SpaceCap;
      owner_r[0] <= '0;
      idx_r    <= '0;
      picked_r <= 1'b0;
      found_r  <= 1'b0;
    end else begin
      if (cmd.init) begin
        space_r <= cfg_space;
        count_r <= CntBits'(1);
        used_r  <= '0;
        start_r[0] <= '0;
        size_r[0]  <= cfg_space;
        owner_r[0] <= '0;
      end
      if (cmd.idx_reset) begin
        idx_r <= '0;
        wr_r <= '0;
      end
      if (cmd.load) begin
        item_r <= in_item;
        picked_r <= 1'b0;
        found_r <= 1'b0;
      end
      if (cmd.scan_step) begin
        if (fits && better) begin
          picked_r <= 1'b1;
          pick_r <= ix;
        end
        idx_r <= idx_r + CntBits'(1);
      end
      if (cmd.set_status) begin
        result_r.status <= cmd.status;
        result_r.start_address <= ((cmd.status == ST_OK) && (item_r.op == OP_REQUEST))
                                  ? start_r[pick_r] : '0;
      end
      if (cmd.exact) begin
        used_r[pick_r] <= 1'b1;
        owner_r[pick_r] <= item_r.owner_id;
      end
      if (cmd.idx_to_count) idx_r <= count_r;
      if (cmd.shift_step && (idx_r > CntBits'(pick_r) + CntBits'(1))) begin
        start_r[ix] <= start_r[ix - IdxBits'(1)];
        size_r[ix]  <= size_r[ix - IdxBits'(1)];
        owner_r[ix] <= owner_r[ix - IdxBits'(1)];
        used_r[ix]  <= used_r[ix - IdxBits'(1)];
        idx_r <= idx_r - CntBits'(1);
      end
      if (cmd.split) begin
        start_r[pick_r + IdxBits'(1)] <= start_r[pick_r] + item_r.request_size[AddrBits-1:0];
        size_r[pick_r + IdxBits'(1)]  <= size_r[pick_r] - item_r.request_size;
        owner_r[pick_r + IdxBits'(1)] <= '0;
        used_r[pick_r + IdxBits'(1)]  <= 1'b0;
        size_r[pick_r]  <= item_r.request_size;
        owner_r[pick_r] <= item_r.owner_id;
        used_r[pick_r]  <= 1'b1;
        count_r <= count_r + CntBits'(1);
      end
      if (cmd.free_step) begin
        if (used_r[ix] && (owner_r[ix] == item_r.owner_id)) begin
          used_r[ix] <= 1'b0;
          owner_r[ix] <= '0;
          found_r <= 1'b1;
        end
        idx_r <= idx_r + CntBits'(1);
      end
      if (cmd.merge_step) begin
        // Entry 0 stays in place; later entries fold into the write pointer.
        if (idx_r == '0) begin
          idx_r <= CntBits'(1);
        end else if (!stat.idx_end) begin
          if (!used_r[ix] && !used_r[wr_r]) begin
            size_r[wr_r] <= size_r[wr_r] + size_r[ix];
          end else begin
            start_r[wr_r + IdxBits'(1)] <= start_r[ix];
            size_r[wr_r + IdxBits'(1)]  <= size_r[ix];
            owner_r[wr_r + IdxBits'(1)] <= owner_r[ix];
            used_r[wr_r + IdxBits'(1)]  <= used_r[ix];
            wr_r <= wr_r + IdxBits'(1);
          end
          idx_r <= idx_r + CntBits'(1);
        end
      end
      if (cmd.clear_step) begin
        count_r <= CntBits'(wr_r) + CntBits'(1);
        for (int i = 0; i < MaxSegments; i++) begin
          if (i > int'(wr_r)) used_r[i] <= 1'b0;
        end
      end
    end
  end

  `CFA_ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1,
    count_r >= CntBits'(1) && count_r <= CntBits'(MaxSegments))
  `CFA_ASSERT_IMPL(a_space_bound, clk, rst_n, 1'b1, space_r != '0 && space_r <= SpaceCap)
  `CFA_ASSERT_NEXT(a_split_grows, clk, rst_n, cmd.split,
    count_r == $past(count_r) + CntBits'(1))
endmodule

// ===== design/contiguous_fit_allocator.sv =====
`timescale 1ns / 1ps
// Channel  Direction  Handshake      Payload
// in_      input      valid / stall  in_item_t (op, owner_id, request_size, fit_mode)
// out_     output     valid / stall  out_item_t (status, start_address)
// cfg_     input      valid / ready  total_space, 21 bits
//
// The serial walk over the segment table sets the time per item. A request scans one
// entry per cycle, then decides; a split first shifts the entries above the picked
// one up by a place. A release walks the table twice, once to free and once to merge,
// or once when the owner holds nothing. Reset is synchronous and leaves one free
// segment of 2^20 units. The result sits in an output register while out_stall is
// high; a following item may be taken meanwhile, but it waits at its end until the
// register is free.
module contiguous_fit_allocator import cfa_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  in_item_t            in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output out_item_t           out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [SizeBits-1:0] cfg_data
);
  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic busy;
  logic out_load;
  logic out_valid_r;
  out_item_t out_data_r;
  out_item_t result;
  logic [SizeBits-1:0] space_clip;

  // A size of zero counts as one; anything above the cap saturates.
  always_comb begin
    space_clip = cfg_data;
    if (cfg_data == '0) space_clip = SizeBits'(1);
    else if (cfg_data > SpaceCap) space_clip = SpaceCap;
  end

  // The output register frees as soon as its item is taken.
  assign in_stall  = busy || cfg_valid;
  assign cfg_ready = !busy;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // The payload only changes when a new result is loaded, never while stalled.
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= result;
    end
  end

  cfa_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_go(in_valid && !in_stall),
    .cfg_go(cfg_valid && !busy),
    .out_free(!out_valid_r || !out_stall),
    .stat(stat), .cmd(cmd), .busy(busy), .out_load(out_load)
  );

  cfa_dp u_dp (
    .clk(clk), .rst_n(rst_n), .in_item(in_data), .cfg_space(space_clip),
    .cmd(cmd), .stat(stat), .result(result)
  );
endmodule

// ===== sim/allocator_checker.sv =====
`timescale 1ns / 1ps
// Watches the item, result and size-register channels of the allocator and
// predicts every result from its own copy of the segment table.
module allocator_checker import cfa_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  in_item_t            in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  out_item_t           out_data,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [SizeBits-1:0] cfg_data,
  output int                  fail_count,
  output int                  pending
);
  logic [AddrBits-1:0] seg_base [MaxSegments];
  logic [SizeBits-1:0] seg_len [MaxSegments];
  logic [IdBits-1:0]   seg_pid [MaxSegments];
  logic                seg_busy [MaxSegments];
  int                  seg_total;
  logic [SizeBits-1:0] space;
  out_item_t           awaited_results[$];

  task automatic report(input string what);
    $display("mismatch at %0t: %s", $time, what);
    fail_count++;
  endtask

  function automatic void clear_table();
    for (int i = 0; i < MaxSegments; i++) begin
      seg_base[i] = '0;
      seg_len[i] = '0;
      seg_pid[i] = '0;
      seg_busy[i] = 1'b0;
    end
    seg_len[0] = space;
    seg_total = 1;
  endfunction

  function automatic out_item_t allocate(input in_item_t it);
    out_item_t r;
    int pick;
    r = '0;
    pick = -1;
    if (it.request_size == '0) begin
      r.status = ST_ZERO;
      return r;
    end
    if (it.fit_mode > FIT_WORST) begin
      r.status = ST_NO_FIT;
      return r;
    end
    for (int i = 0; i < seg_total; i++) begin
      if (seg_busy[i] || seg_len[i] < it.request_size) continue;
      if (pick < 0) begin
        pick = i;
        if (it.fit_mode == FIT_FIRST) break;
      end else if (it.fit_mode == FIT_BEST && seg_len[i] < seg_len[pick]) begin
        pick = i;
      end else if (it.fit_mode == FIT_WORST && seg_len[i] > seg_len[pick]) begin
        pick = i;
      end
    end
    if (pick < 0) begin
      r.status = ST_NO_FIT;
      return r;
    end
    if (seg_len[pick] != it.request_size) begin
      if (seg_total >= MaxSegments) begin
        r.status = ST_FULL;
        return r;
      end
      for (int i = seg_total; i > pick + 1; i--) begin
        seg_base[i] = seg_base[i-1];
        seg_len[i] = seg_len[i-1];
        seg_pid[i] = seg_pid[i-1];
        seg_busy[i] = seg_busy[i-1];
      end
      seg_base[pick+1] = seg_base[pick] + AddrBits'(it.request_size);
      seg_len[pick+1] = seg_len[pick] - it.request_size;
      seg_pid[pick+1] = '0;
      seg_busy[pick+1] = 1'b0;
      seg_len[pick] = it.request_size;
      seg_total++;
    end
    seg_busy[pick] = 1'b1;
    seg_pid[pick] = it.owner_id;
    r.status = ST_OK;
    r.start_address = seg_base[pick];
    return r;
  endfunction

  function automatic out_item_t free_owner(input logic [IdBits-1:0] pid);
    out_item_t r;
    bit hit;
    int w;
    r = '0;
    hit = 0;
    for (int i = 0; i < seg_total; i++) begin
      if (seg_busy[i] && seg_pid[i] == pid) begin
        seg_busy[i] = 1'b0;
        seg_pid[i] = '0;
        hit = 1;
      end
    end
    if (!hit) begin
      r.status = ST_NOT_FOUND;
      return r;
    end
    w = 0;
    for (int i = 1; i < seg_total; i++) begin
      if (!seg_busy[i] && !seg_busy[w]) begin
        seg_len[w] += seg_len[i];
      end else begin
        w++;
        seg_base[w] = seg_base[i];
        seg_len[w] = seg_len[i];
        seg_pid[w] = seg_pid[i];
        seg_busy[w] = seg_busy[i];
      end
    end
    for (int i = w + 1; i < MaxSegments; i++) begin
      seg_base[i] = '0;
      seg_len[i] = '0;
      seg_pid[i] = '0;
      seg_busy[i] = 1'b0;
    end
    seg_total = w + 1;
    r.status = ST_OK;
    return r;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      space = SpaceCap;
      clear_table();
      awaited_results.delete();
      fail_count <= 0;
      pending <= 0;
    end else begin
      // A size write saturates to the valid range and rebuilds the table.
      if (cfg_valid && cfg_ready) begin
        space = (cfg_data == '0) ? SizeBits'(1) : (cfg_data > SpaceCap) ? SpaceCap : cfg_data;
        clear_table();
      end
      if (in_valid && !in_stall)
        awaited_results.push_back(in_data.op == OP_RELEASE ?
                                  free_owner(in_data.owner_id) : allocate(in_data));
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          report("result with no item waiting");
        end else begin
          want = awaited_results.pop_front();
          if (out_data.status !== want.status)
            report($sformatf("status %0d, expected %0d", out_data.status, want.status));
          if (out_data.start_address !== want.start_address)
            report($sformatf("start %0h, expected %0h",
                             out_data.start_address, want.start_address));
        end
      end
      pending <= awaited_results.size();
    end
  end
endmodule

// ===== sim/contiguous_fit_allocator_test.sv =====
`timescale 1ns / 1ps
// Stimulus and verdict for the allocator. The checker beside the block does
// all prediction; this module only offers items, stalls results, writes the
// size register between phases and decides pass or fail.
module contiguous_fit_allocator_test;
  import cfa_pkg::*;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  in_item_t            in_data;
  logic                out_valid;
  logic                out_stall;
  out_item_t           out_data;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [SizeBits-1:0] cfg_data;
  int                  fail_count;
  int                  pending;

  // Percentages of cycles in which the sender idles and the receiver stalls.
  int                  send_idle_pct;
  int                  recv_stall_pct;
  // While set, the receiver stalls without a break so the block backs up.
  bit                  hold_results;
  // Owners used in random traffic; a small pool makes releases hit often.
  int                  owner_pool;

  contiguous_fit_allocator i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  allocator_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // The receiver stalls at random each cycle, or without a break while a
  // long hold-off is running.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= hold_results || ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Offers one item and keeps it steady until the block takes it. Idle
  // cycles are placed only before the valid goes high; the block is busy
  // right after taking an item, so the first wait costs no throughput.
  task automatic send_item(input in_item_t it);
    @(posedge clk);
    while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic send_request(input int pid, input int size, input logic [1:0] mode);
    in_item_t it;
    it.op = OP_REQUEST;
    it.owner_id = IdBits'(pid);
    it.request_size = SizeBits'(size);
    it.fit_mode = mode;
    send_item(it);
  endtask

  task automatic send_release(input int pid);
    in_item_t it;
    it.op = OP_RELEASE;
    it.owner_id = IdBits'(pid);
    it.request_size = SizeBits'($urandom);
    it.fit_mode = 2'($urandom);
    send_item(it);
  endtask

  // Waits until every expected result is in, then lets the block settle so
  // that no release is still merging when the register changes.
  task automatic drain();
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_space(input logic [SizeBits-1:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Random traffic: mostly requests whose sizes suit the memory, with
  // releases of owners from a small pool so the table fills and empties.
  task automatic random_items(input int count, input int space);
    int pick;
    int size;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        send_release($urandom_range(owner_pool - 1));
      end else if (pick < 40) begin
        send_release($urandom);
      end else begin
        case ($urandom_range(9))
          0: size = $urandom_range(2 * space);
          1: size = $urandom;
          2: size = 0;
          default: size = $urandom_range((space + 7) / 8) + 1;
        endcase
        send_request((pick < 45) ? $urandom : $urandom_range(owner_pool - 1),
                     size, 2'($urandom));
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_results = 1'b0;
    owner_pool = 8;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed items on the reset memory size.
    send_request(1, 0, FIT_FIRST);
    send_request(1, 1, FIT_FIRST);
    send_request(2, 1048576, FIT_BEST);
    send_request(3, 2097151, FIT_WORST);
    send_request(4, 100, FIT_BEST);
    send_request(5, 50, FIT_WORST);
    send_request(6, 10, 2'd3);
    send_release(4);
    send_request(7, 100, FIT_BEST);
    send_request(8, 20, FIT_FIRST);
    send_release(9);
    send_release(65535);
    send_request(65535, 1048474, FIT_FIRST);
    send_release(1);
    send_release(65535);
    send_release(0);
    send_request(0, 5, FIT_WORST);
    send_release(0);

    // A tiny memory: a zero write counts as one, and exact fits fill it.
    write_space('0);
    send_request(1, 1, FIT_FIRST);
    send_request(2, 1, FIT_FIRST);
    send_release(1);

    // Many one-unit requests run the table to its limit.
    write_space(SizeBits'(1000));
    for (int i = 0; i < 34; i++) send_request(i, 1, FIT_FIRST);
    send_request(40, 900, FIT_BEST);
    send_release(3);
    send_request(41, 1, FIT_BEST);

    // Random phases with different idling and memory sizes, including a
    // write above the maximum which saturates.
    write_space(SizeBits'(64));
    random_items(250, 64);
    send_idle_pct = 67;
    write_space(SizeBits'(2000));
    random_items(200, 2000);
    send_idle_pct = 0;
    recv_stall_pct = 67;
    write_space('1);
    owner_pool = 16;
    random_items(200, 1048576);
    send_idle_pct = 23;
    recv_stall_pct = 23;
    write_space(SizeBits'(300));
    owner_pool = 8;
    random_items(200, 300);

    // Long hold-off: the output is stalled while items keep coming.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    fork
      begin
        hold_results = 1'b1;
        repeat (400) @(posedge clk);
        hold_results = 1'b0;
      end
      random_items(100, 300);
    join
    write_space(SpaceCap);
    random_items(60, 1048576);

    drain();
    if (fail_count == 0) begin
      $display("contiguous_fit_allocator test passed");
    end else begin
      $display("contiguous_fit_allocator test failed");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("contiguous_fit_allocator test failed");
    $finish;
  end
endmodule

// ===== contiguous_fit_allocator.f =====
+incdir+design
design/cfa_pkg.sv
design/cfa_ctrl.sv
design/cfa_dp.sv
design/contiguous_fit_allocator.sv
sim/allocator_checker.sv
sim/contiguous_fit_allocator_test.sv
